@@ hw/rtl/qsd_pkg.sv @@
// ----------------------------------------------------------------------------
// qsd_pkg
// Shared types and constants for the quadrature step decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qsd_pkg;

   // Step modes; code 3 is unused and decodes as full period
   typedef enum logic [1:0] {
      MODE_FULL    = 2'd0,
      MODE_HALF    = 2'd1,
      MODE_QUARTER = 2'd2
   } mode_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_STEP_MODE = 2'd0;
   localparam logic [1:0] CSR_INVERT_A  = 2'd1;
   localparam logic [1:0] CSR_INVERT_B  = 2'd2;

   // Input commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

   // Phase codes {A,B}
   localparam logic [1:0] PHASE_00 = 2'b00;
   localparam logic [1:0] PHASE_11 = 2'b11;

   // Quarter-period transitions {last_phase, phase}
   localparam logic [3:0] TR_REV_31 = 4'b11_01;
   localparam logic [3:0] TR_REV_10 = 4'b01_00;
   localparam logic [3:0] TR_REV_02 = 4'b00_10;
   localparam logic [3:0] TR_REV_23 = 4'b10_11;
   localparam logic [3:0] TR_FWD_13 = 4'b01_11;
   localparam logic [3:0] TR_FWD_01 = 4'b00_01;
   localparam logic [3:0] TR_FWD_20 = 4'b10_00;
   localparam logic [3:0] TR_FWD_32 = 4'b11_10;

   // Decoder state
   typedef struct packed {
      logic [1:0] last_phase;
      logic       direction;
   } state_type;

   // One decoded item in flight
   typedef struct packed {
      logic       command;
      logic [1:0] phase;
   } item_type;

endpackage

`default_nettype wire

@@ hw/rtl/qsd_rule.sv @@
// ----------------------------------------------------------------------------
// qsd_rule
// Combinational step rule: next state, emit flag and direction for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module qsd_rule (
   input  qsd_pkg::mode_type  mode,
   input  qsd_pkg::item_type  item,
   input  qsd_pkg::state_type state,
   output qsd_pkg::state_type state_next,
   output logic               emit,
   output logic               forward
);
   import qsd_pkg::*;

   logic [3:0] trans;

   assign trans   = {state.last_phase, item.phase};
   assign forward = state_next.direction;

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      if (item.command == CMD_START) begin
         // start: capture reference, or disarm in full-period mode
         if (mode == MODE_HALF || mode == MODE_QUARTER) begin
            state_next.last_phase = item.phase;
         end else begin
            state_next.last_phase = 2'b00;
         end
      end else begin
         case (mode)
            MODE_HALF: begin
               if (item.phase == PHASE_00 || item.phase == PHASE_11) begin
                  if (item.phase != state.last_phase) begin
                     emit                  = 1'b1;
                     state_next.last_phase = item.phase;
                  end
               end else begin
                  state_next.direction = state.last_phase[0] ^ item.phase[0];
               end
            end
            MODE_QUARTER: begin
               state_next.last_phase = item.phase;
               case (trans)
                  TR_REV_31, TR_REV_10, TR_REV_02, TR_REV_23: begin
                     emit                 = 1'b1;
                     state_next.direction = 1'b0;
                  end
                  TR_FWD_13, TR_FWD_01, TR_FWD_20, TR_FWD_32: begin
                     emit                 = 1'b1;
                     state_next.direction = 1'b1;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
            default: begin
               // full period: arm on 11, latch on 01/10, emit on 00
               if (item.phase == PHASE_00) begin
                  if (state.last_phase != 2'b00) begin
                     emit                  = 1'b1;
                     state_next.last_phase = 2'b00;
                  end
               end else if (item.phase == PHASE_11) begin
                  state_next.last_phase = 2'b01;
               end else if (state.last_phase != 2'b00) begin
                  state_next.direction = item.phase[1];
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_step_decoder_core.sv @@
// ----------------------------------------------------------------------------
// quadrature_step_decoder_core
// Decodes quadrature A/B levels into single encoder steps.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a command (sample or start) and
//   the raw A and B pin levels. rsp_* returns one item per reported step,
//   rsp_forward = 1 for +1 and 0 for -1. Items that report no step
//   produce nothing on rsp_*.
//   csr_* writes step_mode, invert_a and invert_b; write only while idle.
// Timing:
//   An item is registered at acceptance, decoded from the input register and
//   its step lands in the output register. One item per cycle is taken while
//   no emitting item waits on a stalled output; the rate is set by the
//   combinational state update in qsd_rule feeding back on the state register.
// Reset:
//   Synchronous, active high; clears the configuration registers, the decoder
//   state and both valid flags.
// Stall:
//   While rsp_ready is low the output register holds its step; if it holds
//   one, an item that would emit waits in the input register and req_ready
//   drops. Items that emit nothing keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_step_decoder_core (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic       req_level_a,
   input  logic       req_level_b,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_forward,
   // configuration port
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [1:0] csr_write_data
);
   import qsd_pkg::*;

   mode_type  mode_ff;
   logic      invert_a_ff;
   logic      invert_b_ff;
   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   logic      item_valid_ff;
   logic      out_valid_ff;
   logic      forward_ff;
   logic      emit;
   logic      forward_next;
   logic      item_go;
   logic      req_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_FULL;
         invert_a_ff <= 1'b0;
         invert_b_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_MODE: mode_ff     <= mode_type'(csr_write_data);
            CSR_INVERT_A:  invert_a_ff <= csr_write_data[0];
            CSR_INVERT_B:  invert_b_ff <= csr_write_data[0];
            default:       ;
         endcase
      end
   end

   // Step rule
   qsd_rule u_rule (
      .mode       (mode_ff),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .emit       (emit),
      .forward    (forward_next)
   );

   // Handshake: a non-emitting item never waits on the output side
   assign item_go   = item_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || item_go;
   assign req_take  = req_valid && req_ready;

   // Input register, levels already inverted and packed {A,B}
   assign item_in.command = req_command;
   assign item_in.phase   = {req_level_a ^ invert_a_ff, req_level_b ^ invert_b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // Decoder state advances as each item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (item_go) begin
         state_ff <= state_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (item_go && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go && emit) begin
         forward_ff <= forward_next;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_forward = forward_ff;

`ifndef SYNTH
   // A held item keeps its payload
   a_item_hold: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !item_go |=> item_valid_ff && $stable(item_ff))
      else $error("held item changed");

   // State only moves when an item leaves
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !item_go |=> $stable(state_ff))
      else $error("state changed without item");

   // An emitting item always lands in the output register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      item_go && emit |=> out_valid_ff && rsp_forward == $past(forward_next))
      else $error("emitted step lost");

   // Reset clears the decoder state
   a_reset_state: assert property (@(posedge clock)
      reset |=> state_ff == '0 && !item_valid_ff && !out_valid_ff)
      else $error("state not cleared by reset");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quadrature_step_decoder_core.
// A driver feeds pin-level items from a queue and decodes each accepted item
// with an in-bench copy of the step rules. A monitor compares every reported
// step with the oldest predicted one. The run covers a directed pass through
// all three step modes, then random phases under changing register settings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qsd_pkg::*;

   localparam int          CLOCK_PERIOD    = 20;
   localparam int          DRAIN_CYCLES    = 4;
   localparam int          RANDOM_PHASES   = 12;
   localparam int          ITEMS_PER_PHASE = 100;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam logic [1:0]  MODE_UNUSED     = 2'd3;
   localparam logic [1:0]  CSR_UNUSED      = 2'd3;
   localparam logic [1:0]  ARMED_FLAG      = 2'b01;

   // raw pin levels plus command, as queued for the driver
   typedef struct packed {
      logic command;
      logic level_a;
      logic level_b;
   } pin_item_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic       req_command      = CMD_SAMPLE;
   logic       req_level_a      = 1'b0;
   logic       req_level_b      = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic       rsp_forward;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index        = CSR_STEP_MODE;
   logic [1:0] csr_write_data   = 2'b00;

   pin_item_type pending_items[$];
   logic         expected_steps[$];

   // decoder copy: registers and state
   logic [1:0]  cur_mode     = MODE_FULL;
   logic        cur_invert_a = 1'b0;
   logic        cur_invert_b = 1'b0;
   logic [1:0]  phase_memory = PHASE_00;
   logic        held_direction = 1'b0;

   // idle odds in percent, shared by both sides; 0 means no idling
   int unsigned idle_odds = 0;
   int unsigned send_gap  = 0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned items_accepted = 0;
   int unsigned starts_accepted = 0;
   int unsigned steps_checked = 0;
   int unsigned csr_writes = 0;

   // stimulus walk state
   logic [1:0]  gray_pos = 2'b00;
   logic        walk_forward = 1'b1;

   quadrature_step_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_level_a      (req_level_a),
      .req_level_b      (req_level_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_forward      (rsp_forward),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Step decode: updates the state copy, tells whether a step is reported
   function automatic void decode_pins(input logic cmd, input logic pin_a,
                                       input logic pin_b, output logic emit,
                                       output logic fwd);
      logic [1:0] phase;
      logic [3:0] trans;
      logic       half_mode;
      logic       quarter_mode;
      phase        = {pin_a ^ cur_invert_a, pin_b ^ cur_invert_b};
      half_mode    = (cur_mode == MODE_HALF);
      quarter_mode = (cur_mode == MODE_QUARTER);
      emit         = 1'b0;
      if (cmd == CMD_START) begin
         // start: reference phase, or disarm in full period
         phase_memory = (half_mode || quarter_mode) ? phase : PHASE_00;
      end else if (half_mode) begin
         if (phase == PHASE_00 || phase == PHASE_11) begin
            if (phase != phase_memory) begin
               emit = 1'b1;
               phase_memory = phase;
            end
         end else begin
            held_direction = phase_memory[0] ^ phase[0];
         end
      end else if (quarter_mode) begin
         trans = {phase_memory, phase};
         phase_memory = phase;
         case (trans)
            TR_REV_31, TR_REV_10, TR_REV_02, TR_REV_23: begin
               emit = 1'b1;
               held_direction = 1'b0;
            end
            TR_FWD_13, TR_FWD_01, TR_FWD_20, TR_FWD_32: begin
               emit = 1'b1;
               held_direction = 1'b1;
            end
            default: ;
         endcase
      end else begin
         // full period, also the unused mode code
         if (phase == PHASE_00) begin
            if (phase_memory != PHASE_00) begin
               emit = 1'b1;
               phase_memory = PHASE_00;
            end
         end else if (phase == PHASE_11) begin
            phase_memory = ARMED_FLAG;
         end else if (phase_memory != PHASE_00) begin
            held_direction = phase[1];
         end
      end
      fwd = held_direction;
   endfunction

   // Driver: presents queued items, decodes each one at acceptance
   always @(posedge clock) begin : drive_items
      pin_item_type next_item;
      logic         emit;
      logic         fwd;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_pins(req_command, req_level_a, req_level_b, emit, fwd);
            if (emit)
               expected_steps.push_back(fwd);
            items_accepted++;
            if (req_command == CMD_START)
               starts_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               next_item = pending_items.pop_front();
               req_valid   <= 1'b1;
               req_command <= next_item.command;
               req_level_a <= next_item.level_a;
               req_level_b <= next_item.level_b;
               if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds)
                  send_gap <= $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks reported steps, stalls the result side in bursts
   always @(posedge clock) begin : check_steps
      logic want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               $error("forward: step reported with none expected, actual %0d",
                      rsp_forward);
               error_count++;
            end else begin
               want = expected_steps.pop_front();
               steps_checked++;
               if (rsp_forward !== want) begin
                  $error("forward mismatch: expected %0d, actual %0d", want,
                         rsp_forward);
                  error_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds)
               stall_left <= $urandom_range(1, 12);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d steps outstanding", cycle_count,
                expected_steps.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_item(input logic cmd, input logic pin_a, input logic pin_b);
      pin_item_type item;
      item.command = cmd;
      item.level_a = pin_a;
      item.level_b = pin_b;
      pending_items.push_back(item);
   endtask

   // Block until all items are taken and every step is back, then let the
   // pipeline flush items that report nothing
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_steps.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] reg_index, input logic [1:0] reg_value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= reg_value;
      case (reg_index)
         CSR_STEP_MODE: cur_mode     = reg_value;
         CSR_INVERT_A:  cur_invert_a = reg_value[0];
         CSR_INVERT_B:  cur_invert_b = reg_value[0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly Gray-code walks with reversals; some starts, repeats and jumps
   task automatic queue_walk(input int count);
      int unsigned roll;
      logic        pin_a;
      logic        pin_b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 10)
            walk_forward = ~walk_forward;
         roll = $urandom_range(0, 99);
         if (roll >= 4 && roll < 80)
            gray_pos = walk_forward ? gray_pos + 2'd1 : gray_pos - 2'd1;
         else if (roll >= 90)
            gray_pos = 2'($urandom_range(0, 3));
         pin_a = gray_pos[1];
         pin_b = gray_pos[1] ^ gray_pos[0];
         push_item((roll < 4) ? CMD_START : CMD_SAMPLE, pin_a, pin_b);
      end
   endtask

   initial begin : run_test
      logic [1:0] mode_value;
      logic [1:0] inv_a_value;
      logic [1:0] inv_b_value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 15;

      // Full period at reset settings: a forward step, unarmed samples, a reverse
      // latch, then a start while armed
      @(negedge clock);
      push_item(CMD_START,  1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b1, 1'b0);
      push_item(CMD_SAMPLE, 1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b0, 1'b1);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b0, 1'b1);
      push_item(CMD_START,  1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b0, 1'b0);

      // Half period: both edge phases, repeats, direction from mid phases
      wait_idle();
      write_csr(CSR_STEP_MODE, MODE_HALF);
      @(negedge clock);
      push_item(CMD_START,  1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b0, 1'b1);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b0, 1'b1);
      push_item(CMD_SAMPLE, 1'b0, 1'b0);

      // Quarter period: all forward and reverse transitions, then a jump
      wait_idle();
      write_csr(CSR_STEP_MODE, MODE_QUARTER);
      @(negedge clock);
      push_item(CMD_START,  1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b0, 1'b1);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b1, 1'b0);
      push_item(CMD_SAMPLE, 1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b1, 1'b0);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);
      push_item(CMD_SAMPLE, 1'b0, 1'b1);
      push_item(CMD_SAMPLE, 1'b0, 1'b0);
      push_item(CMD_SAMPLE, 1'b1, 1'b1);

      // Random phases; state carries over each settings change
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin
               // unused mode code, upper data bits that must be dropped
               mode_value  = MODE_UNUSED;
               inv_a_value = 2'b11;
               inv_b_value = 2'b10;
            end
            1: begin
               mode_value  = MODE_FULL;
               inv_a_value = 2'b01;
               inv_b_value = 2'b01;
            end
            2: begin
               mode_value  = MODE_HALF;
               inv_a_value = 2'b00;
               inv_b_value = 2'b01;
            end
            3: begin
               mode_value  = MODE_QUARTER;
               inv_a_value = 2'b01;
               inv_b_value = 2'b00;
            end
            default: begin
               mode_value  = 2'($urandom_range(0, 3));
               inv_a_value = 2'($urandom_range(0, 3));
               inv_b_value = 2'($urandom_range(0, 3));
            end
         endcase
         write_csr(CSR_STEP_MODE, mode_value);
         write_csr(CSR_INVERT_A, inv_a_value);
         write_csr(CSR_INVERT_B, inv_b_value);
         // index past the register list must leave everything alone
         write_csr(CSR_UNUSED, 2'($urandom_range(0, 3)));
         if (p == RANDOM_PHASES - 1) begin
            idle_odds = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: idle_odds = 0;
               1: idle_odds = 5;
               2: idle_odds = 15;
               default: idle_odds = 35;
            endcase
         end
         @(negedge clock);
         queue_walk(ITEMS_PER_PHASE);
      end
      wait_idle();

      $display("Run covered %0d items (%0d starts) and %0d checked steps",
               items_accepted, starts_accepted, steps_checked);
      $display("over %0d register writes in all step modes and invert settings",
               csr_writes);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ quadrature_step_decoder_core.f @@
hw/rtl/qsd_pkg.sv
hw/rtl/qsd_rule.sv
hw/rtl/quadrature_step_decoder_core.sv
tb/sv/tb_top.sv
